>>> design/erpm_pkg.sv
package erpm_pkg;

   // Frame geometry
   localparam int MOTOR_COUNT  = 4;
   localparam int FRAME_LENGTH = 14;
   localparam int BODY_LEN     = FRAME_LENGTH - 2;
   localparam int CRC_LEN      = FRAME_LENGTH - 4;
   localparam int SHIFT_LEN    = BODY_LEN - 1;
   localparam int CNT_W        = $clog2(BODY_LEN + 1);
   localparam int MOTOR_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   // Sync pattern and CRC seed
   localparam logic [7:0]  SYNC_FIRST  = 8'h0F;
   localparam logic [7:0]  SYNC_SECOND = 8'h02;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;

   // Field widths
   localparam int RPM_W       = 16;
   localparam int PCFG_W      = 12;
   localparam int TICKS_W     = 24;
   localparam int PULSE_W     = 14;
   localparam int MOTOR_IDX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_IDX_W   = 3;

   localparam logic [TICKS_W-1:0] IDLE_MAX  = {TICKS_W{1'b1}};
   localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

   // Divider sizing
   localparam int PROD_W    = RPM_W + PCFG_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_FLOOR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_CEILING   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_PULSE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PULSE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_PULSE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 3'd5;

   // Register reset values
   localparam logic [RPM_W-1:0]   RST_RPM_FLOOR     = 16'd5000;
   localparam logic [RPM_W-1:0]   RST_RPM_CEILING   = 16'd17000;
   localparam logic [PCFG_W-1:0]  RST_STOP_PULSE    = 12'd1000;
   localparam logic [PCFG_W-1:0]  RST_IDLE_PULSE    = 12'd1150;
   localparam logic [PCFG_W-1:0]  RST_FULL_PULSE    = 12'd1980;
   localparam logic [TICKS_W-1:0] RST_TIMEOUT_TICKS = 24'd200000;

   // Controller to datapath commands
   typedef struct packed {
      logic               accept;
      logic               start;
      logic               div_step;
      logic               finish;
      logic               load_out;
      logic               timeout;
      logic               last;
      logic [MOTOR_W-1:0] motor;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic frame_done;
      logic timeout_fire;
      logic out_free;
   } dp_status_type;

   // One byte of the X.25 CRC-16
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

>>> design/erpm_if.sv
interface erpm_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface erpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [erpm_pkg::MOTOR_IDX_W-1:0]    motor_index;
   logic [erpm_pkg::PULSE_W-1:0]        pulse_us;
   logic                                crc_ok;
   logic                                timed_out;
   logic                                last;

   modport source (output valid, output motor_index, output pulse_us, output crc_ok,
                   output timed_out, output last, input ready);
   modport sink (input valid, input motor_index, input pulse_us, input crc_ok,
                 input timed_out, input last, output ready);
endinterface

>>> design/esc_rpm_frame_to_pwm_unit.sv
// ESC rpm frame to motor pulse widths.
// req_if carries one word per event: func 0 with a received serial byte, or
// func 1 for one timer tick. Bytes are taken one per cycle while no run is in
// progress; a byte or tick that completes nothing is absorbed in the cycle it is taken.
// The byte that ends a frame (sync 0x0f 0x02 plus 12 bytes) starts a run of
// four rsp_if words, one per motor, each flagged with the CRC verdict. Each
// word passes through the datapath as one multiply, a restoring divider that
// yields one quotient bit a cycle, a fix-up and a load into the output
// register. A tick that passes the timeout starts a run of four zero words at
// one per cycle while the output register is free.
// req_if.ready is low while a run is in progress; the last word of a run sits
// in the output register while the next bytes are taken. If rsp_if.ready is
// low, the run holds at its next word until the register frees up.
// Reset (synchronous, active high) restores register defaults, drops any
// pending word, returns to sync hunting and clears the tick counter.
// csr_we writes csr_wdata into register csr_index; write only
// while no run is in progress.
module esc_rpm_frame_to_pwm_unit (
   input  logic                               clock,
   input  logic                               reset,
   erpm_req_if.sink                           req_if,
   erpm_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [erpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [erpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import erpm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_if.ready = req_ready;

   // Sequencer
   erpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Receive, arithmetic and output register
   erpm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_if.func),
      .req_rx_byte     (req_if.rx_byte),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_motor_index (rsp_if.motor_index),
      .rsp_pulse_us    (rsp_if.pulse_us),
      .rsp_crc_ok      (rsp_if.crc_ok),
      .rsp_timed_out   (rsp_if.timed_out),
      .rsp_last        (rsp_if.last)
   );

endmodule

>>> design/erpm_ctrl.sv
module erpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  erpm_pkg::dp_status_type status,
   output erpm_pkg::ctrl_cmd_type  cmd
);
   import erpm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIX,
      S_EMIT,
      S_TOUT
   } state_type;

   state_type          state_ff, state_in;
   logic [MOTOR_W-1:0] motor_ff, motor_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               accept;
   logic               last_motor;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign last_motor = (motor_ff == MOTOR_W'(MOTOR_COUNT - 1));

   // Drive datapath commands from the current state
   always_comb begin
      cmd.accept   = accept;
      cmd.start    = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_FIX);
      cmd.load_out = ((state_ff == S_EMIT) || (state_ff == S_TOUT)) && status.out_free;
      cmd.timeout  = (state_ff == S_TOUT);
      cmd.last     = last_motor;
      cmd.motor    = motor_ff;
   end

   // Next state: one word per channel; frame words run multiply, divide, fix-up
   always_comb begin
      state_in = state_ff;
      motor_in = motor_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && status.frame_done) begin
               state_in = S_MUL;
               motor_in = '0;
            end else if (accept && status.timeout_fire) begin
               state_in = S_TOUT;
               motor_in = '0;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
            step_in  = '0;
         end
         S_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               if (last_motor) begin
                  state_in = S_IDLE;
               end else begin
                  motor_in = motor_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_TOUT: begin
            if (status.out_free) begin
               if (last_motor) begin
                  state_in = S_IDLE;
               end else begin
                  motor_in = motor_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         motor_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> design/erpm_dp.sv
module erpm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_func,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 csr_we,
   input  logic [erpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [erpm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  erpm_pkg::ctrl_cmd_type               cmd,
   output erpm_pkg::dp_status_type              status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [erpm_pkg::MOTOR_IDX_W-1:0]     rsp_motor_index,
   output logic [erpm_pkg::PULSE_W-1:0]         rsp_pulse_us,
   output logic                                 rsp_crc_ok,
   output logic                                 rsp_timed_out,
   output logic                                 rsp_last
);
   import erpm_pkg::*;

   // Configuration registers
   logic [RPM_W-1:0]   rpm_floor_ff, rpm_ceiling_ff;
   logic [PCFG_W-1:0]  stop_pulse_ff, idle_pulse_ff, full_pulse_ff;
   logic [TICKS_W-1:0] timeout_ticks_ff;

   // Frame receive state
   logic               prev_sync_ff;
   logic [CNT_W-1:0]   byte_cnt_ff;
   logic [15:0]        crc_ff;
   logic [7:0]         shift_ff [SHIFT_LEN];
   logic [TICKS_W-1:0] idle_cnt_ff;
   logic               reported_ff;
   logic               crc_ok_ff;
   logic [RPM_W-1:0]   rpm_ff [MOTOR_COUNT];

   // Arithmetic state
   logic [PROD_W-1:0]  quo_ff;
   logic [RPM_W-1:0]   rem_ff;
   logic [RPM_W-1:0]   dvs_ff;
   logic               neg_ff, below_ff, zero_ff;
   logic [PULSE_W-1:0] pulse_ff;

   // Output register
   logic                   out_valid_ff;
   logic [MOTOR_IDX_W-1:0] out_motor_ff;
   logic [PULSE_W-1:0]     out_pulse_ff;
   logic                   out_crc_ok_ff, out_timed_out_ff, out_last_ff;

   logic               hunting;
   logic [CNT_W-1:0]   pos;
   logic               frame_done;
   logic               crc_match;
   logic [TICKS_W-1:0] idle_inc;
   logic               timeout_fire;

   logic [RPM_W-1:0]   rpm_sel;
   logic [RPM_W-1:0]   diff;
   logic               span_neg, dvs_neg;
   logic [PCFG_W-1:0]  span_mag;
   logic [RPM_W-1:0]   dvs_mag;
   logic [RPM_W:0]     trial;
   logic               trial_ge;
   logic [SUM_W-1:0]   quo_ext, quo_signed, sum;
   logic [PULSE_W-1:0] clamped, pulse_in;

   // Configuration writes, masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_floor_ff     <= RST_RPM_FLOOR;
         rpm_ceiling_ff   <= RST_RPM_CEILING;
         stop_pulse_ff    <= RST_STOP_PULSE;
         idle_pulse_ff    <= RST_IDLE_PULSE;
         full_pulse_ff    <= RST_FULL_PULSE;
         timeout_ticks_ff <= RST_TIMEOUT_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RPM_FLOOR:     rpm_floor_ff     <= csr_wdata[RPM_W-1:0];
            CSR_RPM_CEILING:   rpm_ceiling_ff   <= csr_wdata[RPM_W-1:0];
            CSR_STOP_PULSE:    stop_pulse_ff    <= csr_wdata[PCFG_W-1:0];
            CSR_IDLE_PULSE:    idle_pulse_ff    <= csr_wdata[PCFG_W-1:0];
            CSR_FULL_PULSE:    full_pulse_ff    <= csr_wdata[PCFG_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Decode the incoming word against receive state
   assign hunting      = (byte_cnt_ff == '0);
   assign pos          = byte_cnt_ff - 1'b1;
   assign frame_done   = !req_func && !hunting && (pos == CNT_W'(BODY_LEN - 1));
   assign crc_match    = ({req_rx_byte, shift_ff[SHIFT_LEN-1]} == crc_ff);
   assign idle_inc     = (idle_cnt_ff < IDLE_MAX) ? idle_cnt_ff + 1'b1 : idle_cnt_ff;
   assign timeout_fire = req_func && (idle_inc > timeout_ticks_ff) && !reported_ff;

   assign status.frame_done   = frame_done;
   assign status.timeout_fire = timeout_fire;
   assign status.out_free     = !out_valid_ff || rsp_ready;

   // Hunt for sync, collect body, run CRC, count silent ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sync_ff <= 1'b0;
         byte_cnt_ff  <= '0;
         crc_ff       <= CRC_INIT;
         idle_cnt_ff  <= '0;
         reported_ff  <= 1'b0;
      end else if (cmd.accept) begin
         if (req_func) begin
            idle_cnt_ff <= idle_inc;
            if (timeout_fire) begin
               reported_ff <= 1'b1;
            end
         end else if (hunting) begin
            if (prev_sync_ff && (req_rx_byte == SYNC_SECOND)) begin
               prev_sync_ff <= 1'b0;
               byte_cnt_ff  <= CNT_W'(1);
               crc_ff       <= CRC_INIT;
            end else begin
               prev_sync_ff <= (req_rx_byte == SYNC_FIRST);
            end
         end else begin
            if (pos < CNT_W'(CRC_LEN)) begin
               crc_ff <= crc_step(crc_ff, req_rx_byte);
            end
            if (frame_done) begin
               byte_cnt_ff  <= '0;
               prev_sync_ff <= 1'b0;
               idle_cnt_ff  <= '0;
               reported_ff  <= 1'b0;
            end else begin
               byte_cnt_ff <= byte_cnt_ff + 1'b1;
            end
         end
      end
   end

   // Shift body bytes in; latch rpm words and CRC verdict at frame end
   always_ff @(posedge clock) begin
      if (cmd.accept && !req_func && !hunting) begin
         if (pos < CNT_W'(SHIFT_LEN)) begin
            for (int i = 0; i < SHIFT_LEN - 1; i++) begin
               shift_ff[i] <= shift_ff[i+1];
            end
            shift_ff[SHIFT_LEN-1] <= req_rx_byte;
         end
         if (frame_done) begin
            crc_ok_ff <= crc_match;
            for (int k = 0; k < MOTOR_COUNT; k++) begin
               rpm_ff[k] <= {shift_ff[(2*k+1) % BODY_LEN], shift_ff[(2*k) % BODY_LEN]};
            end
         end
      end
   end

   // Operands for the selected channel
   assign rpm_sel  = rpm_ff[cmd.motor];
   assign diff     = rpm_sel - rpm_floor_ff;
   assign span_neg = (full_pulse_ff < idle_pulse_ff);
   assign span_mag = span_neg ? idle_pulse_ff - full_pulse_ff : full_pulse_ff - idle_pulse_ff;
   assign dvs_neg  = (rpm_ceiling_ff < rpm_floor_ff);
   assign dvs_mag  = dvs_neg ? rpm_floor_ff - rpm_ceiling_ff : rpm_ceiling_ff - rpm_floor_ff;

   // One restoring divide step
   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});

   // Sign, offset and clamp the quotient; stop pulse below the floor, full pulse when ceiling equals floor
   assign quo_ext    = SUM_W'(quo_ff);
   assign quo_signed = neg_ff ? (~quo_ext + 1'b1) : quo_ext;
   assign sum        = quo_signed + SUM_W'(idle_pulse_ff);

   always_comb begin
      if (sum[SUM_W-1]) begin
         clamped = '0;
      end else if (sum > SUM_W'(PULSE_MAX)) begin
         clamped = PULSE_MAX;
      end else begin
         clamped = sum[PULSE_W-1:0];
      end
      if (below_ff) begin
         pulse_in = PULSE_W'(stop_pulse_ff);
      end else if (zero_ff) begin
         pulse_in = PULSE_W'(full_pulse_ff);
      end else begin
         pulse_in = clamped;
      end
   end

   // Multiply, then divide one quotient bit a cycle, then fix up
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quo_ff   <= PROD_W'(diff) * PROD_W'(span_mag);
         rem_ff   <= '0;
         dvs_ff   <= dvs_mag;
         neg_ff   <= span_neg ^ dvs_neg;
         below_ff <= (rpm_sel < rpm_floor_ff);
         zero_ff  <= (rpm_ceiling_ff == rpm_floor_ff);
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? RPM_W'(trial - {1'b0, dvs_ff}) : trial[RPM_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], trial_ge};
      end
      if (cmd.finish) begin
         pulse_ff <= pulse_in;
      end
   end

   // Output register: load a word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_motor_ff     <= MOTOR_IDX_W'(cmd.motor);
         out_pulse_ff     <= cmd.timeout ? '0 : pulse_ff;
         out_crc_ok_ff    <= cmd.timeout ? 1'b0 : crc_ok_ff;
         out_timed_out_ff <= cmd.timeout;
         out_last_ff      <= cmd.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_motor_index = out_motor_ff;
   assign rsp_pulse_us    = out_pulse_ff;
   assign rsp_crc_ok      = out_crc_ok_ff;
   assign rsp_timed_out   = out_timed_out_ff;
   assign rsp_last        = out_last_ff;

endmodule
